// File: design/pms_pkg.sv
// ----------------------------------------------------------------------------
// pms_pkg
// shared types and constants of the pairing mode sequencer
// ----------------------------------------------------------------------------
package pms_pkg;

    // request codes of an input item
    localparam logic [1:0] REQ_TICK     = 2'd0;
    localparam logic [1:0] REQ_AUTH_ACK = 2'd1;
    localparam logic [1:0] REQ_KEY_ACK  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] CFG_LONG_PRESS   = 3'd0;
    localparam logic [2:0] CFG_SCAN_DUR     = 3'd1;
    localparam logic [2:0] CFG_SCAN_INTV    = 3'd2;
    localparam logic [2:0] CFG_KEY_DUR      = 3'd3;
    localparam logic [2:0] CFG_KEY_INTV     = 3'd4;
    localparam logic [2:0] CFG_BEACON_INTV  = 3'd5;
    localparam logic [2:0] CFG_AUTO_SCAN    = 3'd6;

    // configuration reset values
    localparam logic [15:0] LONG_PRESS_RST  = 16'd3000;
    localparam logic [31:0] SCAN_DUR_RST    = 32'd300000;
    localparam logic [15:0] SCAN_INTV_RST   = 16'd1000;
    localparam logic [15:0] KEY_DUR_RST     = 16'd5000;
    localparam logic [15:0] KEY_INTV_RST    = 16'd500;
    localparam logic [15:0] BEACON_INTV_RST = 16'd1000;

    // time after startup at which the one-time auto scan may start
    localparam logic [31:0] AUTO_SCAN_TIME  = 32'd3000;

    typedef enum logic [1:0] {
        MODE_IDLE = 2'd0,
        MODE_SCAN = 2'd1,
        MODE_KEY  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        ACT_NONE      = 3'd0,
        ACT_SCAN_REQ  = 3'd1,
        ACT_KEY_SEND  = 3'd2,
        ACT_BEACON    = 3'd3,
        ACT_FAIL_ERASE = 3'd4,
        ACT_REGISTER  = 3'd5,
        ACT_DONE      = 3'd6,
        ACT_PEER_FAIL = 3'd7
    } action_t;

    typedef struct packed {
        logic [15:0] long_press_ms;
        logic [31:0] scan_len_ms;
        logic [15:0] scan_interval_ms;
        logic [15:0] key_len_ms;
        logic [15:0] key_gap_ms;
        logic [15:0] beacon_gap_ms;
        logic        auto_scan_enable;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [31:0] now_ms;
        logic        button_down;
        logic [47:0] sender_mac;
        logic        peer_ok;
        logic        registered_present;
    } item_t;

    typedef struct packed {
        action_t     action;
        logic [47:0] target_mac;
        mode_t       mode;
        logic        button_held;
    } result_t;

endpackage

// File: design/pms_cfg_regs.sv
// ----------------------------------------------------------------------------
// pms_cfg_regs
// configuration register file, written through its own valid/ready channel
// ----------------------------------------------------------------------------
module pms_cfg_regs
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [2:0]     cfg_index,
    input  logic [31:0]    cfg_data,
    output pms_pkg::cfg_t  cfg
);

    pms_pkg::cfg_t cfg_reg;
    pms_pkg::cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg = cfg_reg;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                pms_pkg::CFG_LONG_PRESS:  cfg_next.long_press_ms    = cfg_data[15:0];
                pms_pkg::CFG_SCAN_DUR:    cfg_next.scan_len_ms      = cfg_data;
                pms_pkg::CFG_SCAN_INTV:   cfg_next.scan_interval_ms = cfg_data[15:0];
                pms_pkg::CFG_KEY_DUR:     cfg_next.key_len_ms       = cfg_data[15:0];
                pms_pkg::CFG_KEY_INTV:    cfg_next.key_gap_ms       = cfg_data[15:0];
                pms_pkg::CFG_BEACON_INTV: cfg_next.beacon_gap_ms    = cfg_data[15:0];
                pms_pkg::CFG_AUTO_SCAN:   cfg_next.auto_scan_enable = cfg_data[0];
                default:                  cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.long_press_ms    <= pms_pkg::LONG_PRESS_RST;
            cfg_reg.scan_len_ms      <= pms_pkg::SCAN_DUR_RST;
            cfg_reg.scan_interval_ms <= pms_pkg::SCAN_INTV_RST;
            cfg_reg.key_len_ms       <= pms_pkg::KEY_DUR_RST;
            cfg_reg.key_gap_ms       <= pms_pkg::KEY_INTV_RST;
            cfg_reg.beacon_gap_ms    <= pms_pkg::BEACON_INTV_RST;
            cfg_reg.auto_scan_enable <= 1'b0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// File: design/pms_engine.sv
// ----------------------------------------------------------------------------
// pms_engine
// sequencer state and the combinational step logic for one item
// ----------------------------------------------------------------------------
module pms_engine
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              step,
    input  pms_pkg::item_t    item,
    input  pms_pkg::cfg_t     cfg,
    output pms_pkg::result_t  result
);

    pms_pkg::mode_t mode_reg, mode_next;
    logic           btn_latched_reg, btn_latched_next;
    logic           long_done_reg, long_done_next;
    logic           auto_done_reg, auto_done_next;
    logic [31:0]    press_start_reg, press_start_next;
    logic [31:0]    scan_end_reg, scan_end_next;
    logic [31:0]    last_scan_tx_reg, last_scan_tx_next;
    logic [31:0]    key_start_reg, key_start_next;
    logic [31:0]    last_key_tx_reg, last_key_tx_next;
    logic [31:0]    last_beacon_tx_reg, last_beacon_tx_next;
    logic [47:0]    pending_peer_reg, pending_peer_next;

    // intermediate values after auto start and button tracking
    pms_pkg::mode_t mode_auto, mode_btn;
    logic           enter_auto, enter_long;
    logic [31:0]    press_start_btn;
    logic [31:0]    scan_end_btn;
    logic [31:0]    last_scan_btn;
    logic [31:0]    scan_end_calc;
    logic           long_hit;

    pms_pkg::action_t act;
    logic [47:0]      target;

    assign scan_end_calc = item.now_ms + cfg.scan_len_ms;

    always_comb
    begin
        mode_next           = mode_reg;
        btn_latched_next    = btn_latched_reg;
        long_done_next      = long_done_reg;
        auto_done_next      = auto_done_reg;
        press_start_next    = press_start_reg;
        scan_end_next       = scan_end_reg;
        last_scan_tx_next   = last_scan_tx_reg;
        key_start_next      = key_start_reg;
        last_key_tx_next    = last_key_tx_reg;
        last_beacon_tx_next = last_beacon_tx_reg;
        pending_peer_next   = pending_peer_reg;
        act                 = pms_pkg::ACT_NONE;
        target              = 48'd0;

        // auto start
        enter_auto = cfg.auto_scan_enable && !auto_done_reg
                     && (item.now_ms >= pms_pkg::AUTO_SCAN_TIME);
        mode_auto  = (enter_auto && mode_reg == pms_pkg::MODE_IDLE) ? pms_pkg::MODE_SCAN
                                                                    : mode_reg;

        // button tracking
        press_start_btn = (item.button_down && !btn_latched_reg) ? item.now_ms
                                                                 : press_start_reg;
        long_hit   = (item.now_ms - press_start_btn) >= {16'd0, cfg.long_press_ms};
        enter_long = item.button_down && (!long_done_reg || !btn_latched_reg) && long_hit;
        mode_btn   = (enter_long && mode_auto == pms_pkg::MODE_IDLE) ? pms_pkg::MODE_SCAN
                                                                     : mode_auto;

        // both scan entries load the same end time and clear the scan stamp
        if ((enter_auto && mode_reg == pms_pkg::MODE_IDLE)
            || (enter_long && mode_auto == pms_pkg::MODE_IDLE))
        begin
            scan_end_btn  = scan_end_calc;
            last_scan_btn = 32'd0;
        end
        else
        begin
            scan_end_btn  = scan_end_reg;
            last_scan_btn = last_scan_tx_reg;
        end

        case (item.req_type)
            pms_pkg::REQ_TICK:
            begin
                auto_done_next    = auto_done_reg || enter_auto;
                press_start_next  = press_start_btn;
                btn_latched_next  = item.button_down;
                if (item.button_down)
                    long_done_next = (long_done_reg && btn_latched_reg) || long_hit;
                scan_end_next     = scan_end_btn;
                last_scan_tx_next = last_scan_btn;
                mode_next         = mode_btn;

                case (mode_btn)
                    pms_pkg::MODE_SCAN:
                    begin
                        if (item.now_ms >= scan_end_btn)
                            mode_next = pms_pkg::MODE_IDLE;
                        else if ((item.now_ms - last_scan_btn)
                                 >= {16'd0, cfg.scan_interval_ms})
                        begin
                            act               = pms_pkg::ACT_SCAN_REQ;
                            last_scan_tx_next = item.now_ms;
                        end
                    end
                    pms_pkg::MODE_KEY:
                    begin
                        if ((item.now_ms - key_start_reg) > {16'd0, cfg.key_len_ms})
                        begin
                            act       = pms_pkg::ACT_FAIL_ERASE;
                            target    = pending_peer_reg;
                            mode_next = pms_pkg::MODE_IDLE;
                        end
                        else if ((item.now_ms - last_key_tx_reg)
                                 > {16'd0, cfg.key_gap_ms})
                        begin
                            act              = pms_pkg::ACT_KEY_SEND;
                            target           = pending_peer_reg;
                            last_key_tx_next = item.now_ms;
                        end
                    end
                    default:
                    begin
                        if (item.registered_present
                            && (item.now_ms - last_beacon_tx_reg)
                               > {16'd0, cfg.beacon_gap_ms})
                        begin
                            act                 = pms_pkg::ACT_BEACON;
                            last_beacon_tx_next = item.now_ms;
                        end
                    end
                endcase
            end
            pms_pkg::REQ_AUTH_ACK:
            begin
                if (mode_reg == pms_pkg::MODE_SCAN)
                begin
                    target = item.sender_mac;
                    if (!item.peer_ok)
                    begin
                        act       = pms_pkg::ACT_PEER_FAIL;
                        mode_next = pms_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        act               = pms_pkg::ACT_REGISTER;
                        pending_peer_next = item.sender_mac;
                        mode_next         = pms_pkg::MODE_KEY;
                        key_start_next    = item.now_ms;
                        last_key_tx_next  = 32'd0;
                    end
                end
            end
            pms_pkg::REQ_KEY_ACK:
            begin
                if (mode_reg == pms_pkg::MODE_KEY && item.sender_mac == pending_peer_reg)
                begin
                    act               = pms_pkg::ACT_DONE;
                    target            = item.sender_mac;
                    mode_next         = pms_pkg::MODE_IDLE;
                    pending_peer_next = 48'd0;
                end
            end
            default:
            begin
                act = pms_pkg::ACT_NONE;
            end
        endcase

        result.action      = act;
        result.target_mac  = target;
        result.mode        = mode_next;
        result.button_held = btn_latched_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg           <= pms_pkg::MODE_IDLE;
            btn_latched_reg    <= 1'b0;
            long_done_reg      <= 1'b0;
            auto_done_reg      <= 1'b0;
            press_start_reg    <= 32'd0;
            scan_end_reg       <= 32'd0;
            last_scan_tx_reg   <= 32'd0;
            key_start_reg      <= 32'd0;
            last_key_tx_reg    <= 32'd0;
            last_beacon_tx_reg <= 32'd0;
            pending_peer_reg   <= 48'd0;
        end
        else if (step)
        begin
            mode_reg           <= mode_next;
            btn_latched_reg    <= btn_latched_next;
            long_done_reg      <= long_done_next;
            auto_done_reg      <= auto_done_next;
            press_start_reg    <= press_start_next;
            scan_end_reg       <= scan_end_next;
            last_scan_tx_reg   <= last_scan_tx_next;
            key_start_reg      <= key_start_next;
            last_key_tx_reg    <= last_key_tx_next;
            last_beacon_tx_reg <= last_beacon_tx_next;
            pending_peer_reg   <= pending_peer_next;
        end
    end

endmodule

// File: design/pairing_mode_sequencer.sv
// ----------------------------------------------------------------------------
// pairing_mode_sequencer
// pairing handshake sequencer for a link node, driven by timed events
// ----------------------------------------------------------------------------
//
//   channel   direction  handshake               payload
//   -------   ---------  ---------------------   -------------------------------
//   in        sink       in_valid / in_ready     req_type, now_ms, button_down,
//                                                sender_mac, peer_ok,
//                                                registered_present
//   out       source     out_valid / out_ready   action, target_mac, mode,
//                                                button_held
//   cfg       sink       cfg_valid / cfg_ready   cfg_index, cfg_data
//
// one item per cycle sustained while out_ready is high; an item passes through
// the input register, then step logic into the result register
// the sequencer state is updated in the same edge that loads the result, so
// the next item in the input register always sees the updated state
// reset clears all control state and loads the configuration defaults
// a stall on out holds the result register and the input register; in_ready
// drops only while both are full and out_ready is low
// cfg_ready is always high
//
module pairing_mode_sequencer
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  req_type,
    input  logic [31:0] now_ms,
    input  logic        button_down,
    input  logic [47:0] sender_mac,
    input  logic        peer_ok,
    input  logic        registered_present,

    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  action,
    output logic [47:0] target_mac,
    output logic [1:0]  mode,
    output logic        button_held,

    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    pms_pkg::cfg_t    cfg;
    pms_pkg::item_t   item_reg;
    pms_pkg::result_t step_result;
    pms_pkg::result_t result_reg;
    logic             item_valid_reg;
    logic             out_valid_reg;
    logic             advance;
    logic             step;

    // configuration register file
    pms_cfg_regs u_cfg
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    // result register can take a new value when empty or being drained
    assign advance  = !out_valid_reg || out_ready;
    assign step     = item_valid_reg && advance;
    assign in_ready = !item_valid_reg || advance;

    // input register: payload only, no reset needed
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg.req_type           <= req_type;
            item_reg.now_ms             <= now_ms;
            item_reg.button_down        <= button_down;
            item_reg.sender_mac         <= sender_mac;
            item_reg.peer_ok            <= peer_ok;
            item_reg.registered_present <= registered_present;
        end
    end

    // step logic and sequencer state
    pms_engine u_engine
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .step   (step),
        .item   (item_reg),
        .cfg    (cfg),
        .result (step_result)
    );

    // result register payload
    always_ff @(posedge clk)
    begin
        if (step)
            result_reg <= step_result;
    end

    // valid flags of the two stages
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (in_ready)
                item_valid_reg <= in_valid;
            if (advance)
                out_valid_reg <= item_valid_reg;
        end
    end

    assign out_valid   = out_valid_reg;
    assign action      = result_reg.action;
    assign target_mac  = result_reg.target_mac;
    assign mode        = result_reg.mode;
    assign button_held = result_reg.button_held;

endmodule

// File: sim/pairing_mode_sequencer_tb.sv
// ----------------------------------------------------------------------------
// pairing_mode_sequencer_tb
// self-checking bench for the pairing mode sequencer: a directed run through
// every mode, action and corner of the timers, then phases of random event
// streams under changing register settings, checked against a scoreboard
// that tracks the mode, button and timer state of the block
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

class pairing_scoreboard;

    pms_pkg::cfg_t    cfg;
    pms_pkg::mode_t   pair_mode;
    logic             btn_latched;
    logic             long_done;
    logic             auto_done;
    logic [31:0]      press_start;
    logic [31:0]      scan_end;
    logic [31:0]      last_scan_tx;
    logic [31:0]      key_start;
    logic [31:0]      last_key_tx;
    logic [31:0]      last_beacon_tx;
    logic [47:0]      pending_peer;
    pms_pkg::result_t expected_q[$];
    int unsigned      mismatches;

    function new();
        cfg.long_press_ms    = pms_pkg::LONG_PRESS_RST;
        cfg.scan_len_ms      = pms_pkg::SCAN_DUR_RST;
        cfg.scan_interval_ms = pms_pkg::SCAN_INTV_RST;
        cfg.key_len_ms       = pms_pkg::KEY_DUR_RST;
        cfg.key_gap_ms       = pms_pkg::KEY_INTV_RST;
        cfg.beacon_gap_ms    = pms_pkg::BEACON_INTV_RST;
        cfg.auto_scan_enable = 1'b0;
        pair_mode      = pms_pkg::MODE_IDLE;
        btn_latched    = 1'b0;
        long_done      = 1'b0;
        auto_done      = 1'b0;
        press_start    = '0;
        scan_end       = '0;
        last_scan_tx   = '0;
        key_start      = '0;
        last_key_tx    = '0;
        last_beacon_tx = '0;
        pending_peer   = '0;
        mismatches     = 0;
    endfunction

    function void write_reg(logic [2:0] idx, logic [31:0] data);
        case (idx)
            pms_pkg::CFG_LONG_PRESS:  cfg.long_press_ms    = data[15:0];
            pms_pkg::CFG_SCAN_DUR:    cfg.scan_len_ms      = data;
            pms_pkg::CFG_SCAN_INTV:   cfg.scan_interval_ms = data[15:0];
            pms_pkg::CFG_KEY_DUR:     cfg.key_len_ms       = data[15:0];
            pms_pkg::CFG_KEY_INTV:    cfg.key_gap_ms       = data[15:0];
            pms_pkg::CFG_BEACON_INTV: cfg.beacon_gap_ms    = data[15:0];
            pms_pkg::CFG_AUTO_SCAN:   cfg.auto_scan_enable = data[0];
            default: ;
        endcase
    endfunction

    // elapsed time, wrapping modulo 2^32
    function logic [31:0] since(logic [31:0] now, logic [31:0] stamp);
        return now - stamp;
    endfunction

    function void start_scan(logic [31:0] now);
        pair_mode    = pms_pkg::MODE_SCAN;
        scan_end     = now + cfg.scan_len_ms;
        last_scan_tx = '0;
    endfunction

    function void note_item(pms_pkg::item_t it);
        pms_pkg::result_t r;
        r.action     = pms_pkg::ACT_NONE;
        r.target_mac = '0;
        case (it.req_type)
            pms_pkg::REQ_TICK:
            begin
                if (cfg.auto_scan_enable && !auto_done
                    && it.now_ms >= pms_pkg::AUTO_SCAN_TIME)
                begin
                    if (pair_mode == pms_pkg::MODE_IDLE)
                        start_scan(it.now_ms);
                    auto_done = 1'b1;
                end
                if (it.button_down)
                begin
                    if (!btn_latched)
                    begin
                        btn_latched = 1'b1;
                        long_done   = 1'b0;
                        press_start = it.now_ms;
                    end
                    if (!long_done && since(it.now_ms, press_start) >= 32'(cfg.long_press_ms))
                    begin
                        if (pair_mode == pms_pkg::MODE_IDLE)
                            start_scan(it.now_ms);
                        long_done = 1'b1;
                    end
                end
                else
                    btn_latched = 1'b0;

                case (pair_mode)
                    pms_pkg::MODE_SCAN:
                    begin
                        if (it.now_ms >= scan_end)
                            pair_mode = pms_pkg::MODE_IDLE;
                        else if (since(it.now_ms, last_scan_tx) >= 32'(cfg.scan_interval_ms))
                        begin
                            r.action     = pms_pkg::ACT_SCAN_REQ;
                            last_scan_tx = it.now_ms;
                        end
                    end
                    pms_pkg::MODE_KEY:
                    begin
                        if (since(it.now_ms, key_start) > 32'(cfg.key_len_ms))
                        begin
                            r.action     = pms_pkg::ACT_FAIL_ERASE;
                            r.target_mac = pending_peer;
                            pair_mode    = pms_pkg::MODE_IDLE;
                        end
                        else if (since(it.now_ms, last_key_tx) > 32'(cfg.key_gap_ms))
                        begin
                            r.action     = pms_pkg::ACT_KEY_SEND;
                            r.target_mac = pending_peer;
                            last_key_tx  = it.now_ms;
                        end
                    end
                    default:
                    begin
                        if (it.registered_present &&
                            since(it.now_ms, last_beacon_tx) > 32'(cfg.beacon_gap_ms))
                        begin
                            r.action       = pms_pkg::ACT_BEACON;
                            last_beacon_tx = it.now_ms;
                        end
                    end
                endcase
            end
            pms_pkg::REQ_AUTH_ACK:
            begin
                if (pair_mode == pms_pkg::MODE_SCAN)
                begin
                    r.target_mac = it.sender_mac;
                    if (!it.peer_ok)
                    begin
                        r.action  = pms_pkg::ACT_PEER_FAIL;
                        pair_mode = pms_pkg::MODE_IDLE;
                    end
                    else
                    begin
                        r.action     = pms_pkg::ACT_REGISTER;
                        pending_peer = it.sender_mac;
                        pair_mode    = pms_pkg::MODE_KEY;
                        key_start    = it.now_ms;
                        last_key_tx  = '0;
                    end
                end
            end
            pms_pkg::REQ_KEY_ACK:
            begin
                if (pair_mode == pms_pkg::MODE_KEY && it.sender_mac == pending_peer)
                begin
                    r.action     = pms_pkg::ACT_DONE;
                    r.target_mac = it.sender_mac;
                    pair_mode    = pms_pkg::MODE_IDLE;
                    pending_peer = '0;
                end
            end
            default: ;
        endcase
        r.mode        = pair_mode;
        r.button_held = btn_latched;
        expected_q.push_back(r);
    endfunction

    function void check_result(pms_pkg::result_t got);
        pms_pkg::result_t want;
        if (expected_q.size() == 0)
        begin
            mismatches++;
            $display("%0t: result transfer with no item outstanding", $time);
            return;
        end
        want = expected_q.pop_front();
        if (got.action !== want.action)
        begin
            mismatches++;
            $display("%0t: action expected %0d, actual %0d", $time, want.action, got.action);
        end
        if (got.target_mac !== want.target_mac)
        begin
            mismatches++;
            $display("%0t: target_mac expected %h, actual %h", $time,
                     want.target_mac, got.target_mac);
        end
        if (got.mode !== want.mode)
        begin
            mismatches++;
            $display("%0t: mode expected %0d, actual %0d", $time, want.mode, got.mode);
        end
        if (got.button_held !== want.button_held)
        begin
            mismatches++;
            $display("%0t: button_held expected %0d, actual %0d", $time,
                     want.button_held, got.button_held);
        end
    endfunction

    function int unsigned outstanding();
        return expected_q.size();
    endfunction

endclass

module pairing_mode_sequencer_tb;

    // cycle budget of the whole run, far above the slowest legal run
    localparam int unsigned CYCLE_LIMIT   = 1000000;
    localparam int unsigned SETTLE_CYCLES = 6;
    localparam int unsigned PHASES        = 20;
    localparam int unsigned PHASE_ITEMS   = 69;

    // request code and register index that the block does not define
    localparam logic [1:0] REQ_UNUSED = 2'd3;
    localparam logic [2:0] CFG_UNUSED = 3'd7;

    // register settings used by the phases
    typedef enum int { SET_SMALL, SET_ZERO, SET_MAX, SET_RESET, SET_WIDE } setting_t;

    logic        clk;
    logic        rst_n;

    logic        in_valid;
    logic        in_ready;
    logic [1:0]  req_type;
    logic [31:0] now_ms;
    logic        button_down;
    logic [47:0] sender_mac;
    logic        peer_ok;
    logic        registered_present;

    logic        out_valid;
    logic        out_ready;
    logic [2:0]  action;
    logic [47:0] target_mac;
    logic [1:0]  mode;
    logic        button_held;

    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    pairing_scoreboard board;

    // event stream state of the random phases
    logic [31:0] clock_ms;
    logic        btn_level;
    int unsigned btn_left;
    int unsigned step_max;
    logic [47:0] last_auth;
    // no idling on either side while set
    logic        calm;

    int unsigned cycle_count;
    int unsigned stall_left;

    pairing_mode_sequencer dut (.*);

    // 12 ns clock
    always
    begin
        clk = 1'b0;
        #6;
        clk = 1'b1;
        #6;
    end

    // idle stretch: mostly short, now and then long
    function automatic int unsigned idle_len();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 70)
            return $urandom_range(1, 3);
        else if (r < 95)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 60);
    endfunction

    function automatic logic [47:0] rand_mac();
        logic [47:0] m;
        m[31:0]  = $urandom;
        m[47:32] = 16'($urandom_range(0, 65535));
        return m;
    endfunction

    // value written to one register under a given setting
    function automatic logic [31:0] reg_value(setting_t kind, logic [2:0] idx);
        case (kind)
            SET_ZERO: return '0;
            SET_MAX:  return '1;
            SET_WIDE: return $urandom;
            SET_RESET:
            begin
                case (idx)
                    pms_pkg::CFG_LONG_PRESS:  return 32'(pms_pkg::LONG_PRESS_RST);
                    pms_pkg::CFG_SCAN_DUR:    return pms_pkg::SCAN_DUR_RST;
                    pms_pkg::CFG_SCAN_INTV:   return 32'(pms_pkg::SCAN_INTV_RST);
                    pms_pkg::CFG_KEY_DUR:     return 32'(pms_pkg::KEY_DUR_RST);
                    pms_pkg::CFG_KEY_INTV:    return 32'(pms_pkg::KEY_INTV_RST);
                    pms_pkg::CFG_BEACON_INTV: return 32'(pms_pkg::BEACON_INTV_RST);
                    default:                  return '0;
                endcase
            end
            default:
            begin
                // short timers so that one phase walks through every mode
                case (idx)
                    pms_pkg::CFG_LONG_PRESS:  return $urandom_range(0, 20);
                    pms_pkg::CFG_SCAN_DUR:    return $urandom_range(20, 800);
                    pms_pkg::CFG_SCAN_INTV:   return $urandom_range(0, 30);
                    pms_pkg::CFG_KEY_DUR:     return $urandom_range(0, 120);
                    pms_pkg::CFG_KEY_INTV:    return $urandom_range(0, 25);
                    pms_pkg::CFG_BEACON_INTV: return $urandom_range(0, 40);
                    default:                  return $urandom_range(0, 1);
                endcase
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // sampling: every transfer is seen at the edge that completes it, so
    // values read here are the ones the block saw at that edge
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : monitor
        pms_pkg::item_t   seen_item;
        pms_pkg::result_t seen_result;
        if (rst_n)
        begin
            // register writes land in the scoreboard's copy of the settings
            if (cfg_valid && cfg_ready)
                board.write_reg(cfg_index, cfg_data);
            // accepted input item: predict its result
            if (in_valid && in_ready)
            begin
                seen_item.req_type           = req_type;
                seen_item.now_ms             = now_ms;
                seen_item.button_down        = button_down;
                seen_item.sender_mac         = sender_mac;
                seen_item.peer_ok            = peer_ok;
                seen_item.registered_present = registered_present;
                board.note_item(seen_item);
            end
            // accepted result: compare with the oldest prediction
            if (out_valid && out_ready)
            begin
                seen_result.action      = pms_pkg::action_t'(action);
                seen_result.target_mac  = target_mac;
                seen_result.mode        = pms_pkg::mode_t'(mode);
                seen_result.button_held = button_held;
                board.check_result(seen_result);
            end
        end
    end

    // ------------------------------------------------------------------
    // result side back pressure: random stalls, no new ones while calm
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            stall_left = stall_left - 1;
            out_ready <= 1'b0;
        end
        else if (!calm && $urandom_range(0, 99) < 30)
        begin
            stall_left = idle_len() - 1;
            out_ready <= 1'b0;
        end
        else
            out_ready <= 1'b1;
    end

    // ------------------------------------------------------------------
    // watchdog on the cycle count
    // ------------------------------------------------------------------
    initial
    begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("Mismatches found");
        $finish;
    end

    // one input transfer; valid stays up across back to back items
    task automatic send_item(input logic [1:0] req, input logic [31:0] now,
                             input logic btn, input logic [47:0] mac,
                             input logic ok, input logic present);
        int unsigned gap;
        req_type           <= req;
        now_ms             <= now;
        button_down        <= btn;
        sender_mac         <= mac;
        peer_ok            <= ok;
        registered_present <= present;
        in_valid           <= 1'b1;
        do
            @(posedge clk);
        while (!in_ready);
        gap = (calm || $urandom_range(0, 99) < 60) ? 0 : idle_len();
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // one register write; the caller lowers cfg_valid after the last one
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        cfg_index <= idx;
        cfg_data  <= data;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic load_config(input setting_t kind);
        write_reg(pms_pkg::CFG_LONG_PRESS,  reg_value(kind, pms_pkg::CFG_LONG_PRESS));
        write_reg(pms_pkg::CFG_SCAN_DUR,    reg_value(kind, pms_pkg::CFG_SCAN_DUR));
        write_reg(pms_pkg::CFG_SCAN_INTV,   reg_value(kind, pms_pkg::CFG_SCAN_INTV));
        write_reg(pms_pkg::CFG_KEY_DUR,     reg_value(kind, pms_pkg::CFG_KEY_DUR));
        write_reg(pms_pkg::CFG_KEY_INTV,    reg_value(kind, pms_pkg::CFG_KEY_INTV));
        write_reg(pms_pkg::CFG_BEACON_INTV, reg_value(kind, pms_pkg::CFG_BEACON_INTV));
        write_reg(pms_pkg::CFG_AUTO_SCAN,   reg_value(kind, pms_pkg::CFG_AUTO_SCAN));
        // the undefined index must leave every setting alone
        if ($urandom_range(0, 2) == 0)
            write_reg(CFG_UNUSED, $urandom);
        cfg_valid <= 1'b0;
    endtask

    // stop sending and wait until every result is out
    task automatic settle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (board.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // random event stream: mostly ticks with advancing time and held button
    // presses, acknowledges aimed at the pairing flow, some noise
    task automatic run_phase(input int unsigned count);
        logic [47:0] mac;
        int unsigned r;
        for (int unsigned n = 0; n < count; n++)
        begin
            r = $urandom_range(0, 99);
            if (r < 68)
            begin
                r = $urandom_range(0, 99);
                if (r < 82)
                    clock_ms += $urandom_range(0, step_max);
                else if (r < 97)
                    clock_ms += $urandom_range(0, 8 * step_max + 64);
                else
                    clock_ms = $urandom;
                // button alternates between held runs and released runs
                if (btn_left == 0)
                begin
                    btn_level = !btn_level;
                    btn_left  = btn_level ? $urandom_range(1, 12) : $urandom_range(1, 5);
                end
                btn_left--;
                send_item(pms_pkg::REQ_TICK, clock_ms, btn_level, rand_mac(),
                          1'($urandom_range(0, 1)), $urandom_range(0, 3) != 0);
            end
            else if (r < 82)
            begin
                mac       = ($urandom_range(0, 9) == 0) ? '0 : rand_mac();
                last_auth = mac;
                clock_ms += $urandom_range(0, 2);
                send_item(pms_pkg::REQ_AUTH_ACK, clock_ms, 1'($urandom_range(0, 1)), mac,
                          $urandom_range(0, 7) != 0, 1'($urandom_range(0, 1)));
            end
            else if (r < 94)
            begin
                // mostly from the peer that is being paired
                mac = ($urandom_range(0, 3) != 0) ? last_auth : rand_mac();
                clock_ms += $urandom_range(0, 2);
                send_item(pms_pkg::REQ_KEY_ACK, clock_ms, 1'($urandom_range(0, 1)), mac,
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            end
            else if (r < 97)
                send_item(REQ_UNUSED, $urandom, 1'($urandom_range(0, 1)), rand_mac(),
                          1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            else
                send_item(2'($urandom_range(0, 3)), $urandom, 1'($urandom_range(0, 1)),
                          rand_mac(), 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end
    endtask

    // ------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------
    initial
    begin
        setting_t kind;
        board = new();
        rst_n = 1'b0;
        calm  = 1'b0;
        clock_ms  = '0;
        btn_level = 1'b0;
        btn_left  = 0;
        step_max  = 4;
        last_auth = '0;
        in_valid           <= 1'b0;
        req_type           <= pms_pkg::REQ_TICK;
        now_ms             <= '0;
        button_down        <= 1'b0;
        sender_mac         <= '0;
        peer_ok            <= 1'b0;
        registered_present <= 1'b0;
        cfg_valid          <= 1'b0;
        cfg_index          <= pms_pkg::CFG_LONG_PRESS;
        cfg_data           <= '0;

        // reset held, then released at an edge
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: no beacon at the start, one after the interval
        send_item(pms_pkg::REQ_TICK, 32'd0, 1'b0, '0, 1'b0, 1'b1);
        send_item(pms_pkg::REQ_TICK, 32'd1001, 1'b0, '0, 1'b0, 1'b1);
        settle();

        // short timers with auto scan on for the directed walk
        write_reg(pms_pkg::CFG_LONG_PRESS,  32'd2);
        write_reg(pms_pkg::CFG_SCAN_DUR,    32'd50);
        write_reg(pms_pkg::CFG_SCAN_INTV,   32'd5);
        write_reg(pms_pkg::CFG_KEY_DUR,     32'd20);
        write_reg(pms_pkg::CFG_KEY_INTV,    32'd3);
        write_reg(pms_pkg::CFG_BEACON_INTV, 32'd4);
        write_reg(pms_pkg::CFG_AUTO_SCAN,   32'd1);
        cfg_valid <= 1'b0;
        @(posedge clk);

        // auto start just below and at its threshold
        send_item(pms_pkg::REQ_TICK, 32'd2999, 1'b0, '0, 1'b0, 1'b1);
        send_item(pms_pkg::REQ_TICK, 32'd3000, 1'b0, '0, 1'b0, 1'b1);
        // peer add fails during scan
        send_item(pms_pkg::REQ_AUTH_ACK, 32'd3001, 1'b0, 48'h0A0B_0C0D_0E0F, 1'b0, 1'b0);
        // long press into scanning, scan requests at the interval
        send_item(pms_pkg::REQ_TICK, 32'd3010, 1'b1, '0, 1'b0, 1'b0);
        send_item(pms_pkg::REQ_TICK, 32'd3012, 1'b1, '0, 1'b0, 1'b0);
        send_item(pms_pkg::REQ_TICK, 32'd3018, 1'b0, '0, 1'b0, 1'b0);
        // register an all ones peer, key resend, stray and matching key ack
        send_item(pms_pkg::REQ_AUTH_ACK, 32'd3019, 1'b1, '1, 1'b1, 1'b1);
        send_item(pms_pkg::REQ_TICK, 32'd3020, 1'b0, '0, 1'b0, 1'b0);
        send_item(pms_pkg::REQ_KEY_ACK, 32'd3021, 1'b0, 48'h1234_5678_9ABC, 1'b1, 1'b0);
        send_item(pms_pkg::REQ_KEY_ACK, 32'd3022, 1'b0, '1, 1'b1, 1'b0);
        // second pairing with a zero address that gives up
        send_item(pms_pkg::REQ_TICK, 32'd3030, 1'b1, '0, 1'b0, 1'b0);
        send_item(pms_pkg::REQ_TICK, 32'd3032, 1'b1, '0, 1'b0, 1'b0);
        send_item(pms_pkg::REQ_AUTH_ACK, 32'd3033, 1'b1, '0, 1'b1, 1'b1);
        send_item(pms_pkg::REQ_TICK, 32'd3040, 1'b0, '0, 1'b0, 1'b0);
        send_item(pms_pkg::REQ_TICK, 32'd3060, 1'b0, '0, 1'b0, 1'b0);
        // undefined request code with every field set
        send_item(REQ_UNUSED, '1, 1'b1, '1, 1'b1, 1'b1);
        // press across the time wrap, then scan timeout
        send_item(pms_pkg::REQ_TICK, 32'hFFFF_FFFF, 1'b1, '0, 1'b0, 1'b1);
        send_item(pms_pkg::REQ_TICK, 32'd1, 1'b1, '0, 1'b0, 1'b1);
        send_item(pms_pkg::REQ_TICK, 32'h0000_0060, 1'b1, '0, 1'b0, 1'b1);
        // acknowledge while idle is ignored
        send_item(pms_pkg::REQ_AUTH_ACK, 32'h0000_0061, 1'b0, 48'h8000_0000_0001,
                  1'b1, 1'b0);
        // scan entered near the wrap: its end wraps below now and ends at once
        send_item(pms_pkg::REQ_TICK, 32'hFFFF_FFD0, 1'b0, '0, 1'b0, 1'b0);
        send_item(pms_pkg::REQ_TICK, 32'hFFFF_FFE0, 1'b1, '0, 1'b0, 1'b0);
        send_item(pms_pkg::REQ_TICK, 32'hFFFF_FFE2, 1'b1, '0, 1'b0, 1'b0);
        settle();

        // random phases, each under a fresh setting written while idle
        for (int unsigned p = 0; p < PHASES; p++)
        begin
            if (p == 0)
                kind = SET_ZERO;
            else if (p == 1 || p == 14)
                kind = SET_MAX;
            else if (p == 2)
                kind = SET_RESET;
            else if (p == 9)
                kind = SET_WIDE;
            else
                kind = SET_SMALL;
            load_config(kind);
            case (kind)
                SET_ZERO:  step_max = 5;
                SET_RESET: step_max = 400;
                SET_SMALL: step_max = $urandom_range(1, 12);
                default:   step_max = 20000;
            endcase
            // move the time base now and then, sometimes just below the wrap
            case ($urandom_range(0, 9))
                0, 1, 2: clock_ms = $urandom;
                3, 4:    clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 500);
                5:       clock_ms = $urandom_range(0, 100);
                default: ;
            endcase
            calm = (p % 4 == 3);
            run_phase(PHASE_ITEMS);
            settle();
            calm = 1'b0;
        end

        repeat (SETTLE_CYCLES) @(posedge clk);
        if (board.mismatches == 0 && board.outstanding() == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
